FILE: hw/rtl/ssim_pkg.sv
// Shared widths, codes and types of the sparse set index manager.
package ssim_pkg;

   localparam int CMD_W     = 2;
   localparam int ID_W      = 11;
   localparam int CS_W      = 13;
   localparam int ST_W      = 2;
   localparam int SLOT_W    = 8;
   localparam int OFF_W     = 20;
   localparam int CNT_OUT_W = 9;

   localparam int DEF_MAX_ENTITIES = 1024;
   localparam int DEF_MAX_SLOTS    = 256;

   localparam logic [31:0] OFF_MAX = 32'h000F_FFFF;

   localparam logic [CS_W-1:0] COMP_SIZE_RESET = 13'd1;

   typedef logic [CMD_W-1:0]     cmd_type;
   typedef logic [ID_W-1:0]      entity_id_type;
   typedef logic [CS_W-1:0]      comp_size_type;
   typedef logic [ST_W-1:0]      status_type;
   typedef logic [SLOT_W-1:0]    slot_type;
   typedef logic [OFF_W-1:0]     offset_type;
   typedef logic [CNT_OUT_W-1:0] count_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_LOOKUP = 2'd2;
   localparam cmd_type CMD_CLEAR  = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_CONFLICT = 2'd1;
   localparam status_type ST_FULL     = 2'd2;
   localparam status_type ST_BAD_ID   = 2'd3;

endpackage

FILE: hw/rtl/sparse_set_index_manager.sv
// Sparse set index manager top level: sequencer around the entity map and slot owner RAMs.
//
// Usage:
//   req channel (req_valid / req_stall) carries one command word: insert, delete,
//   lookup or clear, plus a 1-based entity id. rsp channel (rsp_valid / rsp_stall)
//   returns exactly one result word per command, in order.
//   csr_wr_en / csr_wr_data write the component size; write it only while idle.
// Sequencing:
//   Insert, lookup and a delete without a move pass the look, execute and output
//   states before the result register loads, then return to idle; a delete that moves
//   the last entry also passes the second delete state, to rewrite the moved entity's map
//   entry through the single map write port. Clear adds a pass over the used slots.
//   One command is in flight at a time; req_stall is high outside the idle state.
// Reset:
//   Reset clears the count and starts a clearing pass over the entity map, one
//   entry per cycle, over all MAX_ENTITIES entries, during which req_stall stays high.
//   The slot owner RAM is not cleared; only owners of slots below the count are used.
// Stall:
//   A result held under rsp_stall keeps its word stable; the next command may be
//   accepted and worked on, and waits at the end for the result register to free.
module sparse_set_index_manager #(
   parameter int MAX_ENTITIES = ssim_pkg::DEF_MAX_ENTITIES,
   parameter int MAX_SLOTS    = ssim_pkg::DEF_MAX_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  ssim_pkg::comp_size_type csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ssim_pkg::cmd_type       req_cmd,
   input  ssim_pkg::entity_id_type req_entity_id,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ssim_pkg::status_type    rsp_status,
   output logic                    rsp_found,
   output ssim_pkg::slot_type      rsp_slot,
   output ssim_pkg::offset_type    rsp_byte_offset,
   output logic                    rsp_moved,
   output ssim_pkg::slot_type      rsp_moved_from_slot,
   output ssim_pkg::entity_id_type rsp_moved_entity,
   output ssim_pkg::count_type     rsp_count_after
);

   import ssim_pkg::*;

   localparam int EIDX_W = $clog2(MAX_ENTITIES);
   localparam int SIDX_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int MAP_W  = SIDX_W + 1;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_LOOK = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_DEL2 = 3'd4;
   localparam logic [2:0] S_CLR  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [EIDX_W-1:0] init_cnt_ff, init_cnt_in;
   logic [CNT_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic              clr_pend_ff, clr_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   comp_size_type     comp_size_ff;

   // latched command word
   cmd_type           cmd_ff;
   entity_id_type     id_ff;
   logic              bad_ff;

   // result under construction
   status_type        res_status_ff, res_status_in;
   logic              res_found_ff, res_found_in;
   logic [SIDX_W-1:0] res_slot_ff, res_slot_in;
   logic              res_moved_ff, res_moved_in;
   logic [SIDX_W-1:0] res_mfrom_ff, res_mfrom_in;
   entity_id_type     res_ment_ff, res_ment_in;

   // output register
   status_type        rsp_status_ff;
   logic              rsp_found_ff;
   slot_type          rsp_slot_ff;
   offset_type        rsp_offset_ff;
   logic              rsp_moved_ff;
   slot_type          rsp_mfrom_ff;
   entity_id_type     rsp_ment_ff;
   count_type         rsp_count_ff;

   // memory ports
   logic              map_we;
   logic [EIDX_W-1:0] map_waddr;
   logic [MAP_W-1:0]  map_wdata;
   logic [EIDX_W-1:0] map_raddr;
   logic [MAP_W-1:0]  map_rdata;
   logic              owner_we;
   logic [SIDX_W-1:0] owner_waddr;
   entity_id_type     owner_wdata;
   logic [SIDX_W-1:0] owner_raddr;
   entity_id_type     owner_rdata;

   // offset unit
   logic              mul_load;
   logic [SIDX_W-1:0] mul_slot;
   offset_type        mul_offset;

   // derived values
   logic              accept;
   logic              out_free;
   logic              bad_in;
   logic [31:0]       id_m1;
   logic [31:0]       mv_m1;
   logic [31:0]       clr_m1;
   logic              map_has;
   logic [SIDX_W-1:0] map_cur;
   logic [CNT_W-1:0]  last_cnt;
   logic [SIDX_W-1:0] last_slot;
   logic [SIDX_W-1:0] count_slot;
   logic              set_full;
   logic              mv_ok;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bad_in   = (req_entity_id == '0) || (32'(req_entity_id) > 32'(MAX_ENTITIES));

   assign id_m1      = 32'(id_ff) - 32'd1;
   assign mv_m1      = 32'(res_ment_ff) - 32'd1;
   assign clr_m1     = 32'(owner_rdata) - 32'd1;
   assign map_has    = map_rdata[SIDX_W];
   assign map_cur    = map_rdata[SIDX_W-1:0];
   assign last_cnt   = count_ff - CNT_W'(1);
   assign last_slot  = last_cnt[SIDX_W-1:0];
   assign count_slot = count_ff[SIDX_W-1:0];
   assign set_full   = 32'(count_ff) >= 32'(MAX_SLOTS);
   assign mv_ok      = (res_ment_ff != '0) && (32'(res_ment_ff) <= 32'(MAX_ENTITIES));

   assign map_raddr  = id_m1[EIDX_W-1:0];
   assign mul_slot   = res_slot_in;

   ssim_ram #(
      .DEPTH (MAX_ENTITIES),
      .WIDTH (MAP_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   ssim_ram #(
      .DEPTH (MAX_SLOTS),
      .WIDTH (ID_W)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (owner_we),
      .wr_addr (owner_waddr),
      .wr_data (owner_wdata),
      .rd_addr (owner_raddr),
      .rd_data (owner_rdata)
   );

   ssim_offset #(
      .SIDX_W (SIDX_W)
   ) u_offset (
      .clock     (clock),
      .load      (mul_load),
      .slot      (mul_slot),
      .comp_size (comp_size_ff),
      .offset    (mul_offset)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      init_cnt_in   = init_cnt_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_pend_in   = 1'b0;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_slot_in   = res_slot_ff;
      res_moved_in  = res_moved_ff;
      res_mfrom_in  = res_mfrom_ff;
      res_ment_in   = res_ment_ff;
      map_we        = 1'b0;
      map_waddr     = map_raddr;
      map_wdata     = '0;
      owner_we      = 1'b0;
      owner_waddr   = count_slot;
      owner_wdata   = id_ff;
      owner_raddr   = last_slot;
      mul_load      = 1'b0;

      unique case (state_ff)
         S_INIT: begin
            // sweep the entity map empty after reset
            map_we      = 1'b1;
            map_waddr   = init_cnt_ff;
            init_cnt_in = init_cnt_ff + EIDX_W'(1);
            if (init_cnt_ff == EIDX_W'(MAX_ENTITIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // map entry of the id and owner of the last slot come back next cycle
            state_in = S_EXEC;
         end
         S_EXEC: begin
            mul_load      = 1'b1;
            res_status_in = ST_OK;
            res_found_in  = 1'b0;
            res_slot_in   = '0;
            res_moved_in  = 1'b0;
            res_mfrom_in  = '0;
            res_ment_in   = '0;
            state_in      = S_OUT;
            if (cmd_ff != CMD_CLEAR && bad_ff) begin
               res_status_in = ST_BAD_ID;
            end else begin
               unique case (cmd_ff)
                  CMD_INSERT: begin
                     res_found_in = map_has;
                     if (map_has) begin
                        res_status_in = ST_CONFLICT;
                        res_slot_in   = map_cur;
                     end else if (set_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        map_we      = 1'b1;
                        map_wdata   = {1'b1, count_slot};
                        owner_we    = 1'b1;
                        owner_waddr = count_slot;
                        owner_wdata = id_ff;
                        count_in    = count_ff + CNT_W'(1);
                        res_slot_in = count_slot;
                     end
                  end
                  CMD_DELETE: begin
                     if (!map_has || (32'(map_cur) >= 32'(count_ff))) begin
                        res_status_in = ST_CONFLICT;
                     end else begin
                        res_found_in = 1'b1;
                        res_slot_in  = map_cur;
                        map_we       = 1'b1;
                        map_wdata    = '0;
                        count_in     = last_cnt;
                        if (map_cur != last_slot) begin
                           // move the last entry into the freed slot
                           res_moved_in = 1'b1;
                           res_mfrom_in = last_slot;
                           res_ment_in  = owner_rdata;
                           owner_we     = 1'b1;
                           owner_waddr  = map_cur;
                           owner_wdata  = owner_rdata;
                           state_in     = S_DEL2;
                        end
                     end
                  end
                  CMD_LOOKUP: begin
                     res_found_in = map_has;
                     if (map_has) begin
                        res_slot_in = map_cur;
                     end else begin
                        res_status_in = ST_CONFLICT;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLR;
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_DEL2: begin
            // repoint the moved entity at its new slot
            if (mv_ok) begin
               map_we    = 1'b1;
               map_waddr = mv_m1[EIDX_W-1:0];
               map_wdata = {1'b1, res_slot_ff};
            end
            state_in = S_OUT;
         end
         S_CLR: begin
            // owner read of the previous cycle drops its map entry
            if (clr_pend_ff && owner_rdata != '0) begin
               map_we    = 1'b1;
               map_waddr = clr_m1[EIDX_W-1:0];
               map_wdata = '0;
            end
            owner_raddr = clr_cnt_ff[SIDX_W-1:0];
            if (clr_cnt_ff < count_ff) begin
               clr_pend_in = 1'b1;
               clr_cnt_in  = clr_cnt_ff + CNT_W'(1);
            end else begin
               count_in = '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register: load when the old word is gone or being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= '0;
         init_cnt_ff  <= '0;
         clr_cnt_ff   <= '0;
         clr_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         comp_size_ff <= COMP_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         init_cnt_ff  <= init_cnt_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_pend_ff  <= clr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            comp_size_ff <= csr_wr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_entity_id;
         bad_ff <= bad_in;
      end
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_slot_ff   <= res_slot_in;
      res_moved_ff  <= res_moved_in;
      res_mfrom_ff  <= res_mfrom_in;
      res_ment_ff   <= res_ment_in;
      if (state_ff == S_OUT && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_slot_ff   <= SLOT_W'(res_slot_ff);
         rsp_offset_ff <= mul_offset;
         rsp_moved_ff  <= res_moved_ff;
         rsp_mfrom_ff  <= SLOT_W'(res_mfrom_ff);
         rsp_ment_ff   <= res_ment_ff;
         rsp_count_ff  <= CNT_OUT_W'(count_ff);
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_byte_offset     = rsp_offset_ff;
   assign rsp_moved           = rsp_moved_ff;
   assign rsp_moved_from_slot = rsp_mfrom_ff;
   assign rsp_moved_entity    = rsp_ment_ff;
   assign rsp_count_after     = rsp_count_ff;

endmodule

FILE: hw/rtl/ssim_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ssim_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/ssim_offset.sv
// Byte offset unit: registered slot times component size, saturated to the offset width.
module ssim_offset #(
   parameter int SIDX_W = 8
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [SIDX_W-1:0]      slot,
   input  ssim_pkg::comp_size_type comp_size,
   output ssim_pkg::offset_type    offset
);

   import ssim_pkg::*;

   localparam int PROD_W = SIDX_W + CS_W;

   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;
   logic [31:0]       product_ext;

   assign product_in  = PROD_W'(slot) * PROD_W'(comp_size);
   assign product_ext = 32'(product_ff);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

   // saturate at the top of the offset range
   always_comb begin
      if (product_ext > OFF_MAX) begin
         offset = OFF_MAX[OFF_W-1:0];
      end else begin
         offset = product_ext[OFF_W-1:0];
      end
   end

endmodule

FILE: hw/rtl/ssim_checker.sv
// Port-level assertions for the sparse set index manager, bound to the top level.
module ssim_checker #(
   parameter int MAX_SLOTS = ssim_pkg::DEF_MAX_SLOTS
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input ssim_pkg::status_type    rsp_status,
   input logic                    rsp_found,
   input ssim_pkg::slot_type      rsp_slot,
   input ssim_pkg::offset_type    rsp_byte_offset,
   input logic                    rsp_moved,
   input ssim_pkg::slot_type      rsp_moved_from_slot,
   input ssim_pkg::entity_id_type rsp_moved_entity,
   input ssim_pkg::count_type     rsp_count_after
);

   import ssim_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
         && $stable(rsp_byte_offset) && $stable(rsp_moved_entity)
         && $stable(rsp_count_after))
      else $error("stalled result word changed");

   // a move only comes from a successful delete of a slot other than the last
   a_move_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_moved |-> rsp_status == ST_OK && rsp_found
         && rsp_moved_from_slot != rsp_slot && rsp_moved_entity != '0)
      else $error("move reported outside a successful delete");

   // a full set reports the full count and no slot
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count_after == CNT_OUT_W'(MAX_SLOTS)
         && !rsp_found && rsp_byte_offset == '0)
      else $error("set full reported with a wrong count");

   // a bad id touches nothing
   a_bad_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BAD_ID |-> !rsp_found && !rsp_moved
         && rsp_slot == '0 && rsp_byte_offset == '0)
      else $error("bad id result carries slot data");

   // the map clearing pass holds off commands right after reset
   a_init_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("command accepted during the clearing pass");

endmodule

bind sparse_set_index_manager ssim_checker #(
   .MAX_SLOTS (MAX_SLOTS)
) u_ssim_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_found           (rsp_found),
   .rsp_slot            (rsp_slot),
   .rsp_byte_offset     (rsp_byte_offset),
   .rsp_moved           (rsp_moved),
   .rsp_moved_from_slot (rsp_moved_from_slot),
   .rsp_moved_entity    (rsp_moved_entity),
   .rsp_count_after     (rsp_count_after)
);
